[design/mcw_pkg.sv]
package mcw_pkg;

    localparam int STATE_W    = 4;
    localparam int NUM_STATES = 1 << STATE_W;
    localparam int SLOT_W     = 2 * STATE_W;
    localparam int NUM_SLOTS  = NUM_STATES * NUM_STATES;

    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int TOTAL_W        = PROB_W + STATE_W;

    localparam logic [TOTAL_W-1:0] ONE_FIXED = TOTAL_W'(1) << PROB_FRAC_BITS;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd2;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } sort_ctrl_t;

    typedef struct packed {
        logic               valid;
        logic               next_valid;
        logic [STATE_W-1:0] dest;
        logic [PROB_W-1:0]  chance;
    } sort_head_t;

endpackage

[design/markov_chain_walk_step.sv]
// Markov chain walker with a 16 x 16 transition table held in a RAM.
// Input channel: in_valid / in_stall carry one beat per item: operation,
// from_state, to_state, probability, random_value. Output channel:
// out_valid / out_stall carry one beat per item: current_state, status.
// Load, place, unused operations and refused steps: in_stall rises for the
// item; its result goes through the finish state to the output register.
// A step reads the 16 entries of the walker's row from the table RAM, one
// per cycle, into an insertion sorter, then walks the sorted list with one
// add and compare per cycle, stopping at the chosen destination.
// One item is worked on at a time; in_stall is low only while idle.
// The result beat sits in an output register; while out_stall is high it
// holds, and a finished item waits for that register before the block
// takes the next item. Reset clears the table's presence bits, the row
// totals and the walker (state zero); the table RAM needs no clearing.
module markov_chain_walk_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mcw_pkg::OP_W-1:0]     operation,
    input  logic [mcw_pkg::STATE_W-1:0]  from_state,
    input  logic [mcw_pkg::STATE_W-1:0]  to_state,
    input  logic [mcw_pkg::PROB_W-1:0]   probability,
    input  logic [mcw_pkg::PROB_W-1:0]   random_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mcw_pkg::STATE_W-1:0]  current_state,
    output logic [mcw_pkg::STATUS_W-1:0] status
);

    import mcw_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [STATE_W-1:0]  walker_reg, walker_next;
    logic [STATE_W-1:0]  row_reg, row_next;
    logic [PROB_W-1:0]   rnd_reg, rnd_next;
    logic [STATE_W:0]    rd_cnt_reg, rd_cnt_next;
    logic [TOTAL_W-1:0]  sum_reg, sum_next;
    logic [STATE_W-1:0]  res_state_reg, res_state_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                rd_pend_reg;
    logic                rd_pres_reg;
    logic [STATE_W-1:0]  rd_dest_reg;

    logic                out_valid_reg;
    logic [STATE_W-1:0]  out_state_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                present_reg   [NUM_SLOTS];
    logic [TOTAL_W-1:0]  row_total_reg [NUM_STATES];

    logic                accept;
    logic                out_free;
    logic [SLOT_W-1:0]   load_slot;
    logic [SLOT_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   pres_addr;
    logic                pres_hit;
    logic [STATE_W-1:0]  tot_addr;
    logic [TOTAL_W-1:0]  tot_sel;
    logic [TOTAL_W-1:0]  sum_add;
    logic                load_wr;
    logic                ram_rd_en;
    logic [PROB_W-1:0]   ram_rd_data;
    sort_ctrl_t          sort_ctrl;
    sort_head_t          head;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_slot = {from_state, to_state};
    assign rd_addr   = {row_reg, rd_cnt_reg[STATE_W-1:0]};
    assign pres_addr = (state_reg == S_READ) ? rd_addr : load_slot;
    assign pres_hit  = present_reg[pres_addr];
    assign tot_addr  = (operation == OP_LOAD) ? from_state : walker_reg;
    assign tot_sel   = row_total_reg[tot_addr];
    assign sum_add   = sum_reg + TOTAL_W'(head.chance);
    assign load_wr   = accept && (operation == OP_LOAD) && !pres_hit;

    always_comb
    begin
        state_next      = state_reg;
        walker_next     = walker_reg;
        row_next        = row_reg;
        rnd_next        = rnd_reg;
        rd_cnt_next     = rd_cnt_reg;
        sum_next        = sum_reg;
        res_state_next  = res_state_reg;
        res_status_next = res_status_reg;
        ram_rd_en       = 1'b0;
        sort_ctrl       = '0;
        sort_ctrl.insert = rd_pend_reg && rd_pres_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_state_next  = walker_reg;
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                    case (operation)
                        OP_LOAD:
                        begin
                            if (pres_hit)
                            begin
                                res_status_next = ST_DUPLICATE;
                            end
                        end
                        OP_STEP:
                        begin
                            row_next = walker_reg;
                            rnd_next = random_value;
                            if (tot_sel != ONE_FIXED)
                            begin
                                res_status_next = ST_REFUSED;
                            end
                            else
                            begin
                                rd_cnt_next     = '0;
                                sort_ctrl.clear = 1'b1;
                                state_next      = S_READ;
                            end
                        end
                        OP_PLACE:
                        begin
                            walker_next    = from_state;
                            res_state_next = from_state;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (!rd_cnt_reg[STATE_W])
                begin
                    ram_rd_en   = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    sum_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!head.valid)
                begin
                    state_next = S_FINISH;
                end
                else if ((TOTAL_W'(rnd_reg) <= sum_add) || !head.next_valid)
                begin
                    walker_next    = head.dest;
                    res_state_next = head.dest;
                    state_next     = S_FINISH;
                end
                else
                begin
                    sort_ctrl.shift = 1'b1;
                    sum_next        = sum_add;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walker_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            walker_reg  <= walker_next;
            rd_pend_reg <= ram_rd_en;
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        rnd_reg        <= rnd_next;
        rd_cnt_reg     <= rd_cnt_next;
        sum_reg        <= sum_next;
        res_state_reg  <= res_state_next;
        res_status_reg <= res_status_next;
        rd_pres_reg    <= pres_hit;
        rd_dest_reg    <= rd_cnt_reg[STATE_W-1:0];
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_state_reg  <= res_state_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                present_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_STATES; i++)
            begin
                row_total_reg[i] <= '0;
            end
        end
        else if (load_wr)
        begin
            present_reg[load_slot]    <= 1'b1;
            row_total_reg[from_state] <= tot_sel + TOTAL_W'(probability);
        end
    end

    mcw_ram #(
        .WIDTH(PROB_W),
        .DEPTH(NUM_SLOTS)
    ) u_table (
        .clk    (clk),
        .wr_en  (load_wr),
        .wr_addr(load_slot),
        .wr_data(probability),
        .rd_en  (ram_rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    mcw_sorter u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sort_ctrl),
        .ins_dest  (rd_dest_reg),
        .ins_chance(ram_rd_data),
        .head      (head)
    );

    assign out_valid     = out_valid_reg;
    assign current_state = out_state_reg;
    assign status        = out_status_reg;

endmodule

[design/mcw_ram.sv]
module mcw_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/mcw_sorter.sv]
module mcw_sorter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mcw_pkg::sort_ctrl_t         ctrl,
    input  logic [mcw_pkg::STATE_W-1:0] ins_dest,
    input  logic [mcw_pkg::PROB_W-1:0]  ins_chance,
    output mcw_pkg::sort_head_t         head
);

    import mcw_pkg::*;

    logic [NUM_STATES-1:0] valid_reg;
    logic [PROB_W-1:0]     chance_reg [NUM_STATES];
    logic [STATE_W-1:0]    dest_reg   [NUM_STATES];

    logic [NUM_STATES-1:0] ahead;
    logic [NUM_STATES-1:0] ahead_prev;
    logic [NUM_STATES-1:0] valid_prev;
    logic [NUM_STATES-1:0] valid_succ;
    logic [PROB_W-1:0]     chance_prev [NUM_STATES];
    logic [PROB_W-1:0]     chance_succ [NUM_STATES];
    logic [STATE_W-1:0]    dest_prev   [NUM_STATES];
    logic [STATE_W-1:0]    dest_succ   [NUM_STATES];

    // ties keep the earlier (lower) destination in front
    always_comb
    begin
        for (int s = 0; s < NUM_STATES; s++)
        begin
            ahead[s] = !valid_reg[s] || (ins_chance > chance_reg[s]);
        end
        ahead_prev[0]  = 1'b0;
        valid_prev[0]  = 1'b0;
        chance_prev[0] = '0;
        dest_prev[0]   = '0;
        for (int s = 1; s < NUM_STATES; s++)
        begin
            ahead_prev[s]  = ahead[s-1];
            valid_prev[s]  = valid_reg[s-1];
            chance_prev[s] = chance_reg[s-1];
            dest_prev[s]   = dest_reg[s-1];
        end
        for (int s = 0; s < NUM_STATES - 1; s++)
        begin
            valid_succ[s]  = valid_reg[s+1];
            chance_succ[s] = chance_reg[s+1];
            dest_succ[s]   = dest_reg[s+1];
        end
        valid_succ[NUM_STATES-1]  = 1'b0;
        chance_succ[NUM_STATES-1] = '0;
        dest_succ[NUM_STATES-1]   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= valid_succ;
        end
        else if (ctrl.insert)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                if (ahead_prev[s])
                begin
                    valid_reg[s] <= valid_prev[s];
                end
                else if (ahead[s])
                begin
                    valid_reg[s] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                chance_reg[s] <= chance_succ[s];
                dest_reg[s]   <= dest_succ[s];
            end
        end
        else if (ctrl.insert)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                if (ahead_prev[s])
                begin
                    chance_reg[s] <= chance_prev[s];
                    dest_reg[s]   <= dest_prev[s];
                end
                else if (ahead[s])
                begin
                    chance_reg[s] <= ins_chance;
                    dest_reg[s]   <= ins_dest;
                end
            end
        end
    end

    assign head.valid      = valid_reg[0];
    assign head.next_valid = valid_reg[1];
    assign head.dest       = dest_reg[0];
    assign head.chance     = chance_reg[0];

endmodule

[dv/tb_markov_chain_walk_step.sv]
`timescale 1ns / 1ps

module tb_markov_chain_walk_step;
    import mcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [PROB_W-1:0] ONE_PROB = 17'h10000;
    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [PROB_W-1:0]  prob;
        logic [PROB_W-1:0]  rnd;
    } walk_cmd_t;

    typedef struct packed {
        logic [STATE_W-1:0]  state;
        logic [STATUS_W-1:0] status;
    } walk_result_t;

    class walk_scoreboard;
        logic [PROB_W-1:0]  chance [NUM_SLOTS];
        bit                 present [NUM_SLOTS];
        logic [TOTAL_W-1:0] row_sum [NUM_STATES];
        logic [STATE_W-1:0] walker;
        walk_result_t       expected_q [$];
        int                 errors;
        int                 steps_taken;
        int                 steps_refused;
        int                 dup_loads;
        int                 results_seen;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                chance[i] = '0;
                present[i] = 1'b0;
            end
            for (int i = 0; i < NUM_STATES; i++)
            begin
                row_sum[i] = '0;
            end
            walker = '0;
            errors = 0;
            steps_taken = 0;
            steps_refused = 0;
            dup_loads = 0;
            results_seen = 0;
        endfunction

        function void note_input(walk_cmd_t c);
            int              slot;
            int              base;
            int              order [NUM_STATES];
            int              count;
            int              j;
            int              next_state;
            bit              found;
            logic [TOTAL_W:0] run_sum;
            walk_result_t    r;
            r.status = ST_OK;
            case (c.op)
                OP_LOAD:
                begin
                    slot = c.src * NUM_STATES + c.dst;
                    if (present[slot])
                    begin
                        r.status = ST_DUPLICATE;
                        dup_loads++;
                    end
                    else
                    begin
                        present[slot] = 1'b1;
                        chance[slot] = c.prob;
                        row_sum[c.src] = row_sum[c.src] + TOTAL_W'(c.prob);
                    end
                end
                OP_STEP:
                begin
                    if (row_sum[walker] != ONE_FIXED)
                    begin
                        r.status = ST_REFUSED;
                        steps_refused++;
                    end
                    else
                    begin
                        base = walker * NUM_STATES;
                        count = 0;
                        // sort present entries by descending chance, lower index first on ties
                        for (int i = 0; i < NUM_STATES; i++)
                        begin
                            if (present[base + i])
                            begin
                                j = count;
                                while (j > 0 && chance[base + i] > chance[base + order[j - 1]])
                                begin
                                    order[j] = order[j - 1];
                                    j--;
                                end
                                order[j] = i;
                                count++;
                            end
                        end
                        steps_taken++;
                        if (count > 0)
                        begin
                            run_sum = '0;
                            found = 1'b0;
                            next_state = order[count - 1];
                            for (int i = 0; i < count; i++)
                            begin
                                if (!found)
                                begin
                                    run_sum = run_sum + chance[base + order[i]];
                                    if (c.rnd <= run_sum)
                                    begin
                                        next_state = order[i];
                                        found = 1'b1;
                                    end
                                end
                            end
                            walker = STATE_W'(next_state);
                        end
                    end
                end
                OP_PLACE:
                begin
                    walker = c.src;
                end
                default:
                begin
                end
            endcase
            r.state = walker;
            expected_q = {expected_q, r};
        endfunction

        function void check_result(logic [STATE_W-1:0] st, logic [STATUS_W-1:0] stat);
            walk_result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing outstanding: current_state=%0d status=%0d",
                       st, stat);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.state)
            begin
                $error("current_state mismatch: expected %0d, actual %0d", e.state, st);
                errors++;
            end
            if (stat !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, stat);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      operation;
    logic [STATE_W-1:0]   from_state;
    logic [STATE_W-1:0]   to_state;
    logic [PROB_W-1:0]    probability;
    logic [PROB_W-1:0]    random_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATE_W-1:0]   current_state;
    logic [STATUS_W-1:0]  status;

    walk_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             long_hold_req;
    int             cycles;

    markov_chain_walk_step DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .from_state    (from_state),
        .to_state      (to_state),
        .probability   (probability),
        .random_value  (random_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_state (current_state),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(current_state, status);
        end
    end

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [STATE_W-1:0] src,
                             input logic [STATE_W-1:0] dst, input logic [PROB_W-1:0] prob,
                             input logic [PROB_W-1:0] rnd);
        walk_cmd_t c;
        c.op = op;
        c.src = src;
        c.dst = dst;
        c.prob = prob;
        c.rnd = rnd;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= c.op;
        from_state <= c.src;
        to_state <= c.dst;
        probability <= c.prob;
        random_value <= c.rnd;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(c);
    endtask

    initial
    begin
        walk_cmd_t load_plan [$];
        walk_cmd_t sent_loads [$];
        walk_cmd_t cmd;
        int        perm [NUM_STATES];
        int        k;
        int        idx;
        int        tmp;
        int        pick;
        int        remaining;
        int        c_val;
        bit        exact;
        bit        quantized;

        sb = new();
        long_hold_req = 1'b0;
        send_idle_pct = 25;
        recv_stall_pct = 66;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        from_state = '0;
        to_state = '0;
        probability = '0;
        random_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty row, unused operation, duplicate load, zero chances and ties
        send_beat(OP_STEP, 0, 0, 0, 0);
        send_beat(OP_UNUSED, 15, 15, ONE_PROB, ONE_PROB);
        send_beat(OP_LOAD, 0, 5, ONE_PROB, 0);
        send_beat(OP_LOAD, 0, 5, 100, 0);
        send_beat(OP_STEP, 0, 0, 0, ONE_PROB);
        send_beat(OP_LOAD, 5, 0, 0, 0);
        send_beat(OP_LOAD, 5, 3, 32768, 0);
        send_beat(OP_LOAD, 5, 9, 32768, 0);
        send_beat(OP_LOAD, 5, 15, 0, 0);
        send_beat(OP_STEP, 0, 0, 0, 0);
        send_beat(OP_STEP, 0, 0, 0, 1);
        send_beat(OP_PLACE, 5, 0, 0, 0);
        send_beat(OP_STEP, 0, 0, 0, 32769);
        send_beat(OP_PLACE, 5, 0, 0, 0);
        // draw above every running sum: lands on the last destination
        send_beat(OP_STEP, 0, 0, 0, 17'h1FFFF);
        send_beat(OP_LOAD, 15, 0, 65535, 0);
        send_beat(OP_STEP, 0, 0, 0, ONE_PROB);
        send_beat(OP_LOAD, 15, 15, 1, 0);
        send_beat(OP_STEP, 0, 0, 0, ONE_PROB);
        send_beat(OP_STEP, 0, 0, 0, 0);
        send_beat(OP_STEP, 0, 0, 0, ONE_PROB);
        send_beat(OP_LOAD, 3, 1, 40000, 0);
        send_beat(OP_LOAD, 3, 2, 40000, 0);
        send_beat(OP_PLACE, 3, 0, 0, 0);
        send_beat(OP_STEP, 0, 0, 0, 30000);
        send_beat(OP_PLACE, 0, 0, 0, 0);

        // plan the remaining rows: most sum to exactly one, some miss by one lsb
        for (int row = 0; row < NUM_STATES; row++)
        begin
            if (row == 0 || row == 3 || row == 5 || row == 15)
                continue;
            for (int i = 0; i < NUM_STATES; i++)
                perm[i] = i;
            for (int i = NUM_STATES - 1; i > 0; i--)
            begin
                idx = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[idx];
                perm[idx] = tmp;
            end
            k = $urandom_range(1, NUM_STATES);
            exact = ($urandom_range(0, 99) < 80);
            quantized = 1'($urandom_range(0, 1));
            remaining = ONE_PROB;
            for (int i = 0; i < k; i++)
            begin
                if (i == k - 1)
                begin
                    c_val = remaining;
                    if (!exact)
                        c_val = (remaining > 0) ? remaining - 1 : 1;
                end
                else if (quantized)
                    c_val = $urandom_range(0, remaining / 4096) * 4096;
                else
                    c_val = $urandom_range(0, remaining);
                remaining -= c_val;
                cmd.op = OP_LOAD;
                cmd.src = STATE_W'(row);
                cmd.dst = STATE_W'(perm[i]);
                cmd.prob = PROB_W'(c_val);
                cmd.rnd = PROB_W'($urandom_range(0, ONE_PROB));
                load_plan = {load_plan, cmd};
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 66;
                recv_stall_pct = 25;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                long_hold_req = 1'b1;
            end
            cmd.src = STATE_W'($urandom_range(0, NUM_STATES - 1));
            cmd.dst = STATE_W'($urandom_range(0, NUM_STATES - 1));
            cmd.prob = PROB_W'($urandom_range(0, ONE_PROB));
            cmd.rnd = PROB_W'($urandom_range(0, ONE_PROB));
            pick = $urandom_range(0, 99);
            if (load_plan.size() > 0 && pick < 30)
            begin
                idx = $urandom_range(0, load_plan.size() - 1);
                cmd = load_plan[idx];
                load_plan.delete(idx);
                sent_loads = {sent_loads, cmd};
            end
            else if (pick < 42)
                cmd.op = OP_PLACE;
            else if (pick < 47)
            begin
                if (sent_loads.size() > 0 && $urandom_range(0, 1))
                begin
                    cmd = sent_loads[$urandom_range(0, sent_loads.size() - 1)];
                    cmd.prob = PROB_W'($urandom_range(0, ONE_PROB));
                end
                else
                    cmd.op = OP_UNUSED;
            end
            else
            begin
                cmd.op = OP_STEP;
                case ($urandom_range(0, 7))
                    0: cmd.rnd = 0;
                    1: cmd.rnd = ONE_PROB;
                    2, 3: cmd.rnd = PROB_W'($urandom_range(0, 16) * 4096);
                    default: cmd.rnd = PROB_W'($urandom_range(0, ONE_PROB));
                endcase
            end
            send_beat(cmd.op, cmd.src, cmd.dst, cmd.prob, cmd.rnd);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result beats in %0d cycles", sb.results_seen, cycles);
        $display("Walk steps taken %0d, steps refused %0d, duplicate loads %0d",
                 sb.steps_taken, sb.steps_refused, sb.dup_loads);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
design/mcw_pkg.sv
design/mcw_ram.sv
design/mcw_sorter.sv
design/markov_chain_walk_step.sv
dv/tb_markov_chain_walk_step.sv
